### rtl/core/mpe_pkg.sv
// ----------------------------------------------------------------------------
// Minimizer pair emitter package
// Shared widths, register indexes, sequencer states and the strand flip.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgChunkIndex = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChunkCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCountLower = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCountUpper = 2'd3;

  // Field widths
  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned HashW = 56;
  localparam int unsigned PosW  = 28;
  localparam int unsigned StepW = 6;

  // Least position distance for a pair
  localparam logic [PosW-1:0] MinSeparation = 28'd100;

  // Last step of each remainder run, one dividend bit per step
  localparam logic [StepW-1:0] TgtLastStep  = 6'd31;
  localparam logic [StepW-1:0] HashLastStep = 6'd55;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StTgt,
    StAnc,
    StItem,
    StEmitF,
    StEmitR
  } mpe_state_e;

  // Map a place word onto the other strand of a read of length len
  function automatic logic [WordW-1:0] flip_place(input logic [WordW-1:0] place,
                                                  input logic [WordW-1:0] mer,
                                                  input logic [HalfW-1:0] len);
    logic [HalfW-1:0] pos;
    logic [HalfW-1:0] r;
    pos = {1'b0, place[31:1]} + 32'd1;
    r   = len - pos + {24'd0, mer[7:0]} - 32'd1;
    return {place[63:32], r[30:0], ~place[0]};
  endfunction

endpackage

### rtl/core/mpe_if.sv
// ----------------------------------------------------------------------------
// Minimizer pair emitter channels
// Input item channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mpe_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_list;
  logic [63:0] mer_word;
  logic [63:0] place_word;
  logic [31:0] occurrences;
  logic [31:0] read_length;

  modport source (output valid, start_of_list, mer_word, place_word, occurrences,
                  read_length, input ready);
  modport sink   (input valid, start_of_list, mer_word, place_word, occurrences,
                  read_length, output ready);
endinterface

interface mpe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_from;
  logic [63:0] key_to;
  logic [63:0] place_from;
  logic [63:0] place_to;
  logic        reversed;
  logic        last;

  modport source (output valid, key_from, key_to, place_from, place_to, reversed,
                  last, input ready);
  modport sink   (input valid, key_from, key_to, place_from, place_to, reversed,
                  last, output ready);
endinterface

### rtl/core/minimizer_pair_emitter.sv
// ----------------------------------------------------------------------------
// Minimizer pair emitter
// Keeps one anchor minimizer and emits forward and reversed pairs per chunk.
// ----------------------------------------------------------------------------
// An item that is rejected, that starts an anchor, or that replaces the anchor
// without forming a pair is taken while the emitter stays idle. An item that
// forms a pair is matched against the chunk by a shared restoring remainder
// unit that handles one bit of the 56-bit hash per cycle, in runs: one reducing
// chunk_index after either chunk register was written, one re-checking the
// anchor hash after such a write or after the anchor changed without a pair,
// and one on the item hash. Each result then waits for its taker, and the
// next item is accepted after the last result has gone. With a chunk count of
// zero the hashes are compared directly and no remainder run takes place.
// ----------------------------------------------------------------------------
module minimizer_pair_emitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mpe_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mpe_pkg::HalfW-1:0]       cfg_wdata_i,
  mpe_in_if.sink                          items_i,
  mpe_out_if.source                       results_o
);

  // Configuration registers
  logic [mpe_pkg::HalfW-1:0] chunk_index_q, chunk_count_q, count_lower_q, count_upper_q;
  logic                      tgt_ok_q, anc_ok_q;

  // Anchor and held item
  logic                      anchor_valid_q, anchor_hit_q;
  logic [mpe_pkg::WordW-1:0] anchor_mer_q, anchor_place_q;
  logic [mpe_pkg::WordW-1:0] itm_mer_q, itm_place_q;
  logic [mpe_pkg::HalfW-1:0] itm_len_q;
  logic                      item_hit_q;

  // Remainder unit
  logic [mpe_pkg::HashW-1:0] div_sr_q;
  logic [mpe_pkg::HalfW-1:0] rem_q, tgt_q;
  logic [mpe_pkg::StepW-1:0] step_q;
  logic [mpe_pkg::HalfW:0]   rem_sh, rem_sub;
  logic [mpe_pkg::HalfW-1:0] rem_nx;
  logic                      step_last, hit_now;

  mpe_pkg::mpe_state_e state_q, state_d;

  // Accept-time decision
  logic                      in_fire, av, lo_ok, first_ok, next_ok, same_read, far;
  logic                      pair, take, zero_cnt, ah_direct, ih_direct;
  logic [mpe_pkg::PosW:0]    sep_diff;
  logic                      commit_in, commit_itm, latch_itm;

  assign zero_cnt  = (chunk_count_q == '0);
  assign in_fire   = items_i.valid & items_i.ready;
  assign av        = anchor_valid_q & ~items_i.start_of_list;
  assign lo_ok     = (items_i.occurrences >= count_lower_q);
  assign first_ok  = lo_ok & (items_i.occurrences < count_upper_q);
  assign next_ok   = lo_ok & (items_i.occurrences <= count_upper_q);
  assign same_read = (anchor_place_q[63:32] == items_i.place_word[63:32]);
  assign sep_diff  = {1'b0, items_i.place_word[28:1]} - {1'b0, anchor_place_q[28:1]};
  // A position before the anchor wraps to a huge distance
  assign far       = sep_diff[mpe_pkg::PosW] |
                     (sep_diff[mpe_pkg::PosW-1:0] >= mpe_pkg::MinSeparation);
  assign pair      = av & next_ok & same_read & far;
  assign take      = av ? next_ok : first_ok;
  assign ah_direct = (anchor_mer_q[63:8] == {24'd0, chunk_index_q});
  assign ih_direct = (items_i.mer_word[63:8] == {24'd0, chunk_index_q});

  // One restoring remainder step
  assign rem_sh    = {rem_q, div_sr_q[mpe_pkg::HashW-1]};
  assign rem_sub   = rem_sh - {1'b0, chunk_count_q};
  assign rem_nx    = rem_sub[mpe_pkg::HalfW] ? rem_sh[mpe_pkg::HalfW-1:0]
                                             : rem_sub[mpe_pkg::HalfW-1:0];
  assign step_last = (state_q == mpe_pkg::StTgt) ? (step_q == mpe_pkg::TgtLastStep)
                                                 : (step_q == mpe_pkg::HashLastStep);
  assign hit_now   = (rem_nx == tgt_q);

  // Sequencer: next state and commit strobes
  always_comb begin
    state_d    = state_q;
    commit_in  = 1'b0;
    commit_itm = 1'b0;
    latch_itm  = 1'b0;
    case (state_q)
      mpe_pkg::StIdle: begin
        if (in_fire) begin
          if (pair && !zero_cnt) begin
            latch_itm = 1'b1;
            if (!tgt_ok_q) begin
              state_d = mpe_pkg::StTgt;
            end else if (!anc_ok_q) begin
              state_d = mpe_pkg::StAnc;
            end else begin
              state_d = mpe_pkg::StItem;
            end
          end else if (pair && (ah_direct || ih_direct)) begin
            latch_itm = 1'b1;
            state_d   = ah_direct ? mpe_pkg::StEmitF : mpe_pkg::StEmitR;
          end else if (take) begin
            commit_in = 1'b1;
          end
        end
      end
      mpe_pkg::StTgt: begin
        if (step_last) begin
          state_d = anc_ok_q ? mpe_pkg::StItem : mpe_pkg::StAnc;
        end
      end
      mpe_pkg::StAnc: begin
        if (step_last) begin
          state_d = mpe_pkg::StItem;
        end
      end
      mpe_pkg::StItem: begin
        if (step_last) begin
          if (anchor_hit_q) begin
            state_d = mpe_pkg::StEmitF;
          end else if (hit_now) begin
            state_d = mpe_pkg::StEmitR;
          end else begin
            state_d    = mpe_pkg::StIdle;
            commit_itm = 1'b1;
          end
        end
      end
      mpe_pkg::StEmitF: begin
        if (results_o.ready) begin
          if (item_hit_q) begin
            state_d = mpe_pkg::StEmitR;
          end else begin
            state_d    = mpe_pkg::StIdle;
            commit_itm = 1'b1;
          end
        end
      end
      mpe_pkg::StEmitR: begin
        if (results_o.ready) begin
          state_d    = mpe_pkg::StIdle;
          commit_itm = 1'b1;
        end
      end
      default: begin
        state_d = mpe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpe_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes; chunk writes invalidate the cached match results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_index_q <= '0;
      chunk_count_q <= 32'd1;
      count_lower_q <= '0;
      count_upper_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpe_pkg::CfgChunkIndex: chunk_index_q <= cfg_wdata_i;
        mpe_pkg::CfgChunkCount: chunk_count_q <= cfg_wdata_i;
        mpe_pkg::CfgCountLower: count_lower_q <= cfg_wdata_i;
        mpe_pkg::CfgCountUpper: count_upper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Cached match flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_ok_q <= 1'b0;
      anc_ok_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == mpe_pkg::CfgChunkIndex ||
                              cfg_idx_i == mpe_pkg::CfgChunkCount)) begin
      tgt_ok_q <= 1'b0;
      anc_ok_q <= 1'b0;
    end else begin
      if (state_q == mpe_pkg::StTgt && step_last) begin
        tgt_ok_q <= 1'b1;
      end
      if (state_q == mpe_pkg::StAnc && step_last) begin
        anc_ok_q <= 1'b1;
      end
      if (commit_in) begin
        anc_ok_q <= 1'b0;
      end else if (commit_itm) begin
        anc_ok_q <= ~zero_cnt;
      end
    end
  end

  // Anchor valid: drop at start of list, set on any new anchor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_valid_q <= 1'b0;
    end else if (in_fire) begin
      anchor_valid_q <= av | take;
    end
  end

  // Anchor payload and match bit
  always_ff @(posedge clk_i) begin
    if (commit_in) begin
      anchor_mer_q   <= items_i.mer_word;
      anchor_place_q <= items_i.place_word;
    end else if (commit_itm) begin
      anchor_mer_q   <= itm_mer_q;
      anchor_place_q <= itm_place_q;
      anchor_hit_q   <= (state_q == mpe_pkg::StItem) ? hit_now : item_hit_q;
    end else if (state_q == mpe_pkg::StAnc && step_last) begin
      anchor_hit_q <= hit_now;
    end else if (latch_itm && zero_cnt) begin
      anchor_hit_q <= ah_direct;
    end
  end

  // Held item
  always_ff @(posedge clk_i) begin
    if (latch_itm) begin
      itm_mer_q   <= items_i.mer_word;
      itm_place_q <= items_i.place_word;
      itm_len_q   <= items_i.read_length;
      item_hit_q  <= ih_direct;
    end else if (state_q == mpe_pkg::StItem && step_last) begin
      item_hit_q <= hit_now;
    end
  end

  // Remainder unit: load on entry to a run, else shift one bit
  always_ff @(posedge clk_i) begin
    if (state_d != state_q && state_d == mpe_pkg::StTgt) begin
      div_sr_q <= {chunk_index_q, 24'd0};
      rem_q    <= '0;
      step_q   <= '0;
    end else if (state_d != state_q && state_d == mpe_pkg::StAnc) begin
      div_sr_q <= anchor_mer_q[63:8];
      rem_q    <= '0;
      step_q   <= '0;
    end else if (state_d != state_q && state_d == mpe_pkg::StItem) begin
      div_sr_q <= (state_q == mpe_pkg::StIdle) ? items_i.mer_word[63:8] : itm_mer_q[63:8];
      rem_q    <= '0;
      step_q   <= '0;
    end else if (state_q == mpe_pkg::StTgt || state_q == mpe_pkg::StAnc ||
                 state_q == mpe_pkg::StItem) begin
      div_sr_q <= {div_sr_q[mpe_pkg::HashW-2:0], 1'b0};
      rem_q    <= rem_nx;
      step_q   <= step_q + 6'd1;
    end
    if (state_q == mpe_pkg::StTgt && step_last) begin
      tgt_q <= rem_nx;
    end
  end

  // Handshakes and result payload
  assign items_i.ready    = (state_q == mpe_pkg::StIdle);
  assign results_o.valid  = (state_q == mpe_pkg::StEmitF) || (state_q == mpe_pkg::StEmitR);

  always_comb begin
    if (state_q == mpe_pkg::StEmitR) begin
      results_o.key_from   = itm_mer_q;
      results_o.key_to     = anchor_mer_q;
      results_o.place_from = mpe_pkg::flip_place(itm_place_q, itm_mer_q, itm_len_q);
      results_o.place_to   = mpe_pkg::flip_place(anchor_place_q, anchor_mer_q, itm_len_q);
      results_o.reversed   = 1'b1;
      results_o.last       = 1'b1;
    end else begin
      results_o.key_from   = anchor_mer_q;
      results_o.key_to     = itm_mer_q;
      results_o.place_from = anchor_place_q;
      results_o.place_to   = itm_place_q;
      results_o.reversed   = 1'b0;
      results_o.last       = ~item_hit_q;
    end
  end

endmodule

### tb/sv/mpe_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimizer pair checker
// Watches the configuration port and both channels of the pair emitter. On
// every accepted input item it advances its own copy of the anchor state and
// queues the pairs the item should produce. Every accepted result is compared
// field by field with the oldest queued pair.
// ----------------------------------------------------------------------------
module mpe_pair_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mpe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mpe_pkg::HalfW-1:0]   cfg_wdata_i,
  mpe_in_if                           items_mon,
  mpe_out_if                          results_mon,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          items_o,
  output int                          fwd_pairs_o,
  output int                          rev_pairs_o
);

  typedef struct packed {
    logic [63:0] key_from;
    logic [63:0] key_to;
    logic [63:0] place_from;
    logic [63:0] place_to;
    logic        reversed;
    logic        last;
  } pair_t;

  // Register copies
  logic [31:0] chunk_idx;
  logic [31:0] chunk_cnt;
  logic [31:0] cnt_lo;
  logic [31:0] cnt_hi;

  // Anchor copy
  logic        anchor_ok;
  logic [63:0] anchor_mer;
  logic [63:0] anchor_place;

  pair_t pairs_due[$];

  // Does the hash of this mer word fall into the served chunk
  function automatic logic chunk_hit(input logic [63:0] mer);
    logic [55:0] h;
    h = mer[63:8];
    if (chunk_cnt == 32'd0) return h == {24'd0, chunk_idx};
    return (h % {24'd0, chunk_cnt}) == {24'd0, chunk_idx % chunk_cnt};
  endfunction

  // Move a place word onto the opposite strand, wrapping at 32 bits
  function automatic logic [63:0] other_strand(input logic [63:0] place,
                                               input logic [63:0] mer,
                                               input logic [31:0] len);
    logic [31:0] start;
    logic [31:0] rpos;
    logic [31:0] shifted;
    start   = (place[31:0] >> 1) + 32'd1;
    rpos    = len - start + {24'd0, mer[7:0]} - 32'd1;
    shifted = rpos << 1;
    return ((place & 64'hFFFF_FFFF_0000_0001) | {32'd0, shifted}) ^ 64'd1;
  endfunction

  // Advance the anchor and queue the pairs caused by one item
  task automatic predict_item(input logic sol, input logic [63:0] mer,
                              input logic [63:0] place, input logic [31:0] occ,
                              input logic [31:0] len);
    pair_t       found[2];
    int          n;
    logic [63:0] gap;
    n = 0;
    if (sol) anchor_ok = 1'b0;
    if (!anchor_ok) begin
      if (occ >= cnt_lo && occ < cnt_hi) begin
        anchor_ok    = 1'b1;
        anchor_mer   = mer;
        anchor_place = place;
      end
      return;
    end
    if (occ < cnt_lo || occ > cnt_hi) return;
    if (anchor_place[63:32] == place[63:32]) begin
      gap = {36'd0, place[28:1]} - {36'd0, anchor_place[28:1]};
      if (gap >= {36'd0, mpe_pkg::MinSeparation}) begin
        if (chunk_hit(anchor_mer)) begin
          found[n] = '{anchor_mer, mer, anchor_place, place, 1'b0, 1'b0};
          n++;
          fwd_pairs_o++;
        end
        if (chunk_hit(mer)) begin
          found[n] = '{mer, anchor_mer, other_strand(place, mer, len),
                       other_strand(anchor_place, anchor_mer, len), 1'b1, 1'b0};
          n++;
          rev_pairs_o++;
        end
      end
    end
    anchor_mer   = mer;
    anchor_place = place;
    if (n > 0) found[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pairs_due.push_back(found[k]);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_cnt_o++;
    end
  endtask

  // Follow register writes, score results, then predict on new items
  always @(posedge clk_i or negedge rst_ni) begin
    pair_t want;
    if (!rst_ni) begin
      chunk_idx    = 32'd0;
      chunk_cnt    = 32'd1;
      cnt_lo       = 32'd0;
      cnt_hi       = 32'hFFFF_FFFF;
      anchor_ok    = 1'b0;
      anchor_mer   = 64'd0;
      anchor_place = 64'd0;
      pairs_due.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
      items_o      = 0;
      fwd_pairs_o  = 0;
      rev_pairs_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mpe_pkg::CfgChunkIndex: chunk_idx = cfg_wdata_i;
          mpe_pkg::CfgChunkCount: chunk_cnt = cfg_wdata_i;
          mpe_pkg::CfgCountLower: cnt_lo    = cfg_wdata_i;
          mpe_pkg::CfgCountUpper: cnt_hi    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (results_mon.valid === 1'b1 && results_mon.ready === 1'b1) begin
        if (pairs_due.size() == 0) begin
          $error("unexpected pair: key_from %h key_to %h reversed %b",
                 results_mon.key_from, results_mon.key_to, results_mon.reversed);
          fail_cnt_o++;
        end else begin
          want = pairs_due.pop_front();
          check_field("key_from", want.key_from, results_mon.key_from);
          check_field("key_to", want.key_to, results_mon.key_to);
          check_field("place_from", want.place_from, results_mon.place_from);
          check_field("place_to", want.place_to, results_mon.place_to);
          check_field("reversed", {63'd0, want.reversed}, {63'd0, results_mon.reversed});
          check_field("last", {63'd0, want.last}, {63'd0, results_mon.last});
        end
      end
      if (items_mon.valid === 1'b1 && items_mon.ready === 1'b1) begin
        items_o++;
        predict_item(items_mon.start_of_list, items_mon.mer_word, items_mon.place_word,
                     items_mon.occurrences, items_mon.read_length);
      end
      pending_o = pairs_due.size();
    end
  end

endmodule

### tb/sv/minimizer_pair_emitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimizer pair emitter testbench
// Drives a directed run over the count limits, separation and strand flip
// corners, then read-shaped random streams under several register settings.
// Items arrive in bursts, results are taken on a changing stall pattern, and
// a separate checker scores every pair.
// ----------------------------------------------------------------------------
module minimizer_pair_emitter_tb;

  localparam int SettleCycles = 250;
  localparam int DrainLimit   = 100000;

  typedef enum int {TakeAll, TakeHalf, TakeQuarter, TakeEighth} take_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  int fail_cnt;
  int pending;
  int items_seen;
  int fwd_pairs;
  int rev_pairs;

  // Shadow of the registers, used to aim hashes at the served chunk
  logic [31:0] cur_idx = 32'd0;
  logic [31:0] cur_cnt = 32'd1;
  logic [31:0] cur_lo  = 32'd0;
  logic [31:0] cur_hi  = 32'hFFFF_FFFF;

  int         burst_left = 4;
  take_mode_e take_mode  = TakeAll;
  int         take_left  = 100;
  int         take_tick  = 0;
  int         waited;

  mpe_in_if  items_if ();
  mpe_out_if results_if ();

  minimizer_pair_emitter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .items_i     (items_if),
    .results_o   (results_if)
  );

  mpe_pair_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .items_mon   (items_if),
    .results_mon (results_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .items_o     (items_seen),
    .fwd_pairs_o (fwd_pairs),
    .rev_pairs_o (rev_pairs)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Stall the result channel on a pattern that is picked anew at random when take_left runs out
  always @(posedge clk_i) begin
    if (take_left == 0) begin
      take_mode <= take_mode_e'($urandom_range(0, 3));
      take_left <= $urandom_range(50, 400);
    end else begin
      take_left <= take_left - 1;
    end
    take_tick <= take_tick + 1;
    case (take_mode)
      TakeAll:     results_if.ready <= 1'b1;
      TakeHalf:    results_if.ready <= 1'($urandom_range(0, 1));
      TakeQuarter: results_if.ready <= ($urandom_range(0, 3) == 0);
      default:     results_if.ready <= (take_tick % 8 == 0);
    endcase
  end

  function automatic logic [63:0] mk_place(input logic [31:0] rid, input logic [30:0] pos,
                                           input logic strand);
    return {rid, pos, strand};
  endfunction

  function automatic logic [63:0] mk_mer(input logic [55:0] hash, input logic [7:0] span);
    return {hash, span};
  endfunction

  // Random mer word, aimed at the served chunk when hit is set
  function automatic logic [63:0] pick_mer(input logic hit);
    logic [63:0] w;
    logic [63:0] k;
    w = {$urandom, $urandom};
    k = {40'd0, 24'($urandom)};
    if (hit && cur_cnt == 32'd0) w[63:8] = {24'd0, cur_idx};
    else if (hit) w[63:8] = 56'(k * {32'd0, cur_cnt} + {32'd0, cur_idx % cur_cnt});
    return w;
  endfunction

  // Occurrence count: mostly inside the limits, with edges and strays
  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return cur_lo;
      2: return cur_hi;
      3: return cur_lo - 32'd1;
      4: return cur_hi + 32'd1;
      default: begin
        if (cur_hi >= cur_lo) return $urandom_range(cur_hi, cur_lo);
        return $urandom;
      end
    endcase
  endfunction

  // Hold until every queued pair has come back
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Offer one item, hold until taken, then maybe open a gap
  task automatic send_item(input logic sol, input logic [63:0] mer, input logic [63:0] place,
                           input logic [31:0] occ, input logic [31:0] len);
    items_if.valid         <= 1'b1;
    items_if.start_of_list <= sol;
    items_if.mer_word      <= mer;
    items_if.place_word    <= place;
    items_if.occurrences   <= occ;
    items_if.read_length   <= len;
    do @(posedge clk_i); while (items_if.ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      items_if.valid <= 1'b0;
      if ($urandom_range(0, 39) == 0) wait_drained();
      else repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
    end
  endtask

  // Drop valid, drain, and let any pair-less remainder run finish
  task automatic settle_idle();
    items_if.valid <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      mpe_pkg::CfgChunkIndex: cur_idx = val;
      mpe_pkg::CfgChunkCount: cur_cnt = val;
      mpe_pkg::CfgCountLower: cur_lo  = val;
      mpe_pkg::CfgCountUpper: cur_hi  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] idx, input logic [31:0] cnt,
                            input logic [31:0] lo, input logic [31:0] hi);
    settle_idle();
    write_reg(mpe_pkg::CfgChunkIndex, idx);
    write_reg(mpe_pkg::CfgChunkCount, cnt);
    write_reg(mpe_pkg::CfgCountLower, lo);
    write_reg(mpe_pkg::CfgCountUpper, hi);
  endtask

  // Mostly reads walked in position order, with stray items mixed in
  task automatic run_random(input int n);
    int          sent;
    int          seq_len;
    logic [31:0] rid;
    logic [31:0] len;
    logic [30:0] pos;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom_range(0, 1)), pick_mer(1'($urandom_range(0, 1))),
                  {$urandom, $urandom}, pick_count(), $urandom);
        sent++;
      end else begin
        rid     = $urandom;
        pos     = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
        len     = ($urandom_range(0, 3) == 0) ? $urandom : {1'b0, pos} + $urandom_range(0, 8000);
        seq_len = $urandom_range(2, 12);
        for (int j = 0; j < seq_len && sent < n; j++) begin
          case ($urandom_range(0, 11))
            0:       pos = pos + 31'($urandom_range(0, 99));
            1:       pos = pos - 31'($urandom_range(1, 500));
            2:       pos = pos + 31'd100;
            default: pos = pos + 31'($urandom_range(100, 3000));
          endcase
          send_item(j == 0 || $urandom_range(0, 24) == 0, pick_mer($urandom_range(0, 2) != 0),
                    mk_place(($urandom_range(0, 14) == 0) ? $urandom : rid, pos,
                             1'($urandom_range(0, 1))),
                    pick_count(), len);
          sent++;
        end
      end
    end
  endtask

  initial begin
    #15_000_000;
    $display("minimizer_pair_emitter test failed");
    $finish;
  end

  initial begin
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = 2'd0;
    cfg_wdata              = 32'd0;
    items_if.valid         = 1'b0;
    items_if.start_of_list = 1'b0;
    items_if.mer_word      = 64'd0;
    items_if.place_word    = 64'd0;
    items_if.occurrences   = 32'd0;
    items_if.read_length   = 32'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: count limit edges, exact separation, wraps, read change
    send_item(1'b1, mk_mer(56'h11, 8'd20), mk_place(32'h1, 31'd50, 1'b0), 32'hFFFF_FFFF, 32'd1000);
    send_item(1'b0, mk_mer(56'h11, 8'd20), mk_place(32'h1, 31'd50, 1'b0), 32'd0, 32'd1000);
    send_item(1'b0, mk_mer(56'h22, 8'd15), mk_place(32'h1, 31'd150, 1'b1), 32'hFFFF_FFFF,
              32'd1000);
    send_item(1'b0, mk_mer(56'h33, 8'd31), mk_place(32'h1, 31'd249, 1'b0), 32'd7, 32'd1000);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_FFFF_FFFF, 32'd5, 32'd0);
    send_item(1'b0, 64'd0, mk_place(32'h1, 31'd0, 1'b0), 32'd0, 32'hFFFF_FFFF);
    send_item(1'b0, mk_mer(56'h44, 8'd9), mk_place(32'h2, 31'd500, 1'b0), 32'd3, 32'd800);
    send_item(1'b1, mk_mer(56'h55, 8'd9), mk_place(32'h2, 31'd900, 1'b1), 32'd3, 32'd800);
    send_item(1'b0, mk_mer(56'h66, 8'd9), mk_place(32'h2, 31'd2000, 1'b0), 32'd3, 32'd800);

    // Two chunks, counts 10..20: one-sided pairs and rejected counts
    set_config(32'd1, 32'd2, 32'd10, 32'd20);
    send_item(1'b1, mk_mer(56'h2468, 8'd12), mk_place(32'h3, 31'd10, 1'b0), 32'd9, 32'd300);
    send_item(1'b0, mk_mer(56'h2468, 8'd12), mk_place(32'h3, 31'd10, 1'b0), 32'd20, 32'd300);
    send_item(1'b0, mk_mer(56'h2468, 8'd12), mk_place(32'h3, 31'd10, 1'b0), 32'd10, 32'd300);
    send_item(1'b0, mk_mer(56'h1357, 8'd12), mk_place(32'h3, 31'd400, 1'b0), 32'd21, 32'd300);
    send_item(1'b0, mk_mer(56'h1357, 8'd12), mk_place(32'h3, 31'd400, 1'b1), 32'd20, 32'd300);
    send_item(1'b0, mk_mer(56'h8642, 8'd12), mk_place(32'h3, 31'd600, 1'b0), 32'd15, 32'd300);
    send_item(1'b0, mk_mer(56'h8a42, 8'd12), mk_place(32'h3, 31'd800, 1'b1), 32'd10, 32'd300);
    send_item(1'b0, mk_mer(56'h7531, 8'd12), mk_place(32'h3, 31'd1000, 1'b0), 32'd9, 32'd300);

    // Zero chunk count: hashes match only when equal to the chunk index
    set_config(32'hABCD_1234, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(1'b1, mk_mer(56'hABCD_1234, 8'd7), mk_place(32'h4, 31'd0, 1'b0), 32'd1, 32'd100);
    send_item(1'b0, pick_mer(1'b0), mk_place(32'h4, 31'd300, 1'b0), 32'd1, 32'd100);
    send_item(1'b0, mk_mer(56'h1_ABCD_1234, 8'd7), mk_place(32'h4, 31'd600, 1'b0), 32'd1,
              32'd100);
    send_item(1'b0, mk_mer(56'hABCD_1234, 8'd7), mk_place(32'h4, 31'd900, 1'b1), 32'd1, 32'd100);

    // Random reads over a range of settings
    run_random(100);
    set_config(32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF);
    run_random(150);
    set_config(32'd5, 32'd3, 32'd10, 32'd1000);
    run_random(150);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    run_random(120);
    set_config($urandom, $urandom_range(2, 16), 32'd40, 32'd40);
    run_random(50);
    set_config($urandom, $urandom, $urandom_range(0, 65535), $urandom_range(65536, 1 << 30));
    run_random(150);
    set_config(32'd7, 32'd64, 32'd0, 32'h7FFF_FFFF);
    run_random(150);

    // Drain and give the verdict
    items_if.valid <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (pending != 0) $error("%0d expected pairs never arrived", pending);
    $display("Covered %0d items over nine register settings: %0d forward, %0d reversed pairs.",
             items_seen, fwd_pairs, rev_pairs);
    if (fail_cnt == 0 && pending == 0) begin
      $display("minimizer_pair_emitter test passed");
    end else begin
      $display("minimizer_pair_emitter test failed");
    end
    $finish;
  end

endmodule
